@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/ecc_pkg.sv @@
package ecc_pkg;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [15:0] HOLD_TICKS_RST = 16'd300;
    localparam logic [15:0] IDLE_TICKS_RST = 16'd500;

    // Configuration register indexes
    localparam logic REG_HOLD_TICKS = 1'b0;
    localparam logic REG_IDLE_TICKS = 1'b1;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef struct packed {
        logic       tick;
        logic [2:0] floor;
        logic [3:0] floor_press;
        logic       up_press;
        logic       down_press;
        logic       motor_halt;
    } item_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       stepped;
        logic [1:0] mode;
        logic       holding;
        logic [3:0] pending_calls;
        logic [1:0] direction;
    } result_t;

    // Eight-phase half-step pattern, first winding in bit 3
    function automatic logic [3:0] coil_lookup(input logic [2:0] ph);
        logic [3:0] pat;
        case (ph)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // Calls that a press may toggle: only floors ahead of the car
    function automatic logic [3:0] ahead_mask(input logic [3:0] press,
                                              input logic [2:0] fl,
                                              input logic       dir_up);
        logic [3:0] mask;
        logic [2:0] flr;
        for (int i = 0; i < 4; i++) begin
            flr = 3'(i + 1);
            mask[i] = press[i] && (dir_up ? (fl < flr) : (fl > flr));
        end
        return mask;
    endfunction

endpackage

@@ hw/rtl/ecc_in_stage.sv @@
module ecc_in_stage
    import ecc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t item_in,
    input  logic  take,
    output logic  item_vld,
    output item_t item_out
);

    logic  vld_reg;
    item_t item_reg;

    // Accept a new word whenever the held one is empty or leaves this cycle
    assign in_ready = !vld_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_vld = vld_reg;
    assign item_out = item_reg;

endmodule

@@ hw/rtl/ecc_core.sv @@
module ecc_core
    import ecc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        fire,
    input  item_t       item,
    output result_t     result
);

    logic [15:0] hold_ticks_reg, idle_ticks_reg;
    logic        hold_reg, up_reg, down_reg, stopped_reg;
    logic [2:0]  last_reg, phase_reg;
    logic [3:0]  calls_reg, coil_reg;
    logic [1:0]  dir_reg;
    logic [15:0] hc_reg, ic_reg;

    logic        hold_next, up_next, down_next, stopped_next;
    logic [2:0]  last_next, phase_next;
    logic [3:0]  calls_next, coil_next;
    logic [1:0]  dir_next;
    logic [15:0] hc_next, ic_next;
    logic        stepped_now;
    logic [1:0]  arr_idx;
    logic        on_floor;
    logic [1:0]  mode_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_TICKS_RST;
            idle_ticks_reg <= IDLE_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HOLD_TICKS: hold_ticks_reg <= cfg_data;
                REG_IDLE_TICKS: idle_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        hold_next    = hold_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        stopped_next = stopped_reg;
        last_next    = last_reg;
        phase_next   = phase_reg;
        calls_next   = calls_reg;
        coil_next    = coil_reg;
        dir_next     = dir_reg;
        stepped_now  = 1'b0;
        hc_next = (item.tick && hc_reg != CNT_MAX) ? hc_reg + 16'd1 : hc_reg;
        ic_next = (item.tick && ic_reg != CNT_MAX) ? ic_reg + 16'd1 : ic_reg;
        arr_idx  = 2'(item.floor - 3'd1);
        on_floor = (item.floor >= 3'd1) && (item.floor <= 3'd4);

        if (hold_reg)
        begin
            if (hc_next >= hold_ticks_reg)
            begin
                hold_next = 1'b0;
            end
            if (dir_reg == DIR_UP || dir_reg == DIR_DOWN)
            begin
                calls_next = calls_reg ^ ahead_mask(item.floor_press, item.floor,
                                                    dir_reg == DIR_UP);
            end
        end
        else if (up_reg && !item.motor_halt)
        begin
            hc_next = '0;
            if (last_reg != item.floor && on_floor)
            begin
                last_next = item.floor;
                if (calls_reg[arr_idx])
                begin
                    calls_next[arr_idx] = 1'b0;
                    hold_next = 1'b1;
                end
            end
            if (calls_next != 4'd0)
            begin
                dir_next    = DIR_UP;
                coil_next   = coil_lookup(phase_reg);
                phase_next  = phase_reg + 3'd1;
                stepped_now = 1'b1;
            end
            else
            begin
                dir_next = DIR_NONE;
                if (ic_next >= idle_ticks_reg)
                begin
                    up_next      = 1'b0;
                    stopped_next = 1'b1;
                end
            end
            calls_next = calls_next ^ ahead_mask(item.floor_press, item.floor, 1'b1);
            // Reverse only once the upward calls are exhausted
            if (item.down_press && calls_next == 4'd0)
            begin
                up_next   = 1'b0;
                down_next = 1'b1;
            end
        end
        else if (down_reg && !item.motor_halt)
        begin
            hc_next = '0;
            if (last_reg != item.floor && on_floor)
            begin
                last_next = item.floor;
                if (calls_reg[arr_idx])
                begin
                    calls_next[arr_idx] = 1'b0;
                    hold_next = 1'b1;
                end
            end
            // A new reading off floors 1 to 4, between floors included, also holds
            if (last_next != item.floor)
            begin
                last_next = item.floor;
                hold_next = 1'b1;
            end
            if (calls_next != 4'd0)
            begin
                dir_next    = DIR_DOWN;
                coil_next   = coil_lookup(phase_reg);
                phase_next  = phase_reg - 3'd1;
                stepped_now = 1'b1;
            end
            else
            begin
                dir_next = DIR_NONE;
                if (ic_next >= idle_ticks_reg)
                begin
                    down_next    = 1'b0;
                    stopped_next = 1'b1;
                end
            end
            if (item.up_press && calls_next == 4'd0)
            begin
                up_next   = 1'b1;
                down_next = 1'b0;
            end
            calls_next = calls_next ^ ahead_mask(item.floor_press, item.floor, 1'b0);
        end
        else if (stopped_reg)
        begin
            last_next = item.floor;
            if (item.up_press)
            begin
                up_next      = 1'b1;
                stopped_next = 1'b0;
                ic_next      = '0;
            end
            else if (item.down_press)
            begin
                down_next    = 1'b1;
                stopped_next = 1'b0;
                ic_next      = '0;
            end
        end

        if (up_next)
        begin
            mode_now = MODE_UP;
        end
        else if (down_next)
        begin
            mode_now = MODE_DOWN;
        end
        else if (stopped_next)
        begin
            mode_now = MODE_STOP;
        end
        else
        begin
            mode_now = MODE_NONE;
        end

        result.coils         = coil_next;
        result.stepped       = stepped_now;
        result.mode          = mode_now;
        result.holding       = hold_next;
        result.pending_calls = calls_next;
        result.direction     = dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= 1'b0;
            up_reg      <= 1'b0;
            down_reg    <= 1'b0;
            stopped_reg <= 1'b1;
            last_reg    <= 3'd0;
            phase_reg   <= 3'd0;
            calls_reg   <= 4'd0;
            coil_reg    <= 4'd0;
            dir_reg     <= DIR_NONE;
            hc_reg      <= 16'd0;
            ic_reg      <= 16'd0;
        end
        else if (fire)
        begin
            hold_reg    <= hold_next;
            up_reg      <= up_next;
            down_reg    <= down_next;
            stopped_reg <= stopped_next;
            last_reg    <= last_next;
            phase_reg   <= phase_next;
            calls_reg   <= calls_next;
            coil_reg    <= coil_next;
            dir_reg     <= dir_next;
            hc_reg      <= hc_next;
            ic_reg      <= ic_next;
        end
    end

endmodule

@@ hw/rtl/ecc_out_stage.sv @@
module ecc_out_stage
    import ecc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result_out
);

    logic    vld_reg;
    result_t result_reg;

    // Free when empty or when the held word is taken this cycle
    assign room = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (room)
        begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = vld_reg;
    assign result_out = result_reg;

endmodule

@@ hw/rtl/elevator_call_controller_core.sv @@
// Call controller for a four-floor elevator car, one control pass per word.
// Input channel (in_valid/in_ready): tick, floor, floor_press, up_press,
// down_press, motor_halt for one pass. Output channel (out_valid/out_ready):
// coils, stepped, mode, holding, pending_calls, direction after that pass.
// Configuration: cfg_wr_en with cfg_index 0 writes hold_ticks, index 1
// writes idle_ticks; write only while no word is in flight.
// Path: an accepted word is held in the input register, and its pass
// result is then loaded into the result register, which presents it
// on the output channel.
// Throughput: one word per cycle while out_ready is high; the pass logic is
// combinational between the input register and the result register, and the
// control state it updates is registered at the same edge as the result.
// Reset: car stopped, no calls, counters and coil phase at zero, windings
// off, hold_ticks 300, idle_ticks 500; both channels empty.
// Stall: when out_ready is low the result register holds its word; the
// input register still takes one more word, then in_ready drops until
// the output drains.
module elevator_call_controller_core
    import ecc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        tick,
    input  logic [2:0]  floor,
    input  logic [3:0]  floor_press,
    input  logic        up_press,
    input  logic        down_press,
    input  logic        motor_halt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  coils,
    output logic        stepped,
    output logic [1:0]  mode,
    output logic        holding,
    output logic [3:0]  pending_calls,
    output logic [1:0]  direction
);

    item_t   item_in, item_q;
    logic    item_vld, room, fire;
    result_t result_d, result_q;

    assign item_in.tick        = tick;
    assign item_in.floor       = floor;
    assign item_in.floor_press = floor_press;
    assign item_in.up_press    = up_press;
    assign item_in.down_press  = down_press;
    assign item_in.motor_halt  = motor_halt;

    // Advance one pass when a word is held and the result slot is free
    assign fire = item_vld && room;

    ecc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item_in  (item_in),
        .take     (fire),
        .item_vld (item_vld),
        .item_out (item_q)
    );

    ecc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item_q),
        .result    (result_d)
    );

    ecc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result_in  (result_d),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_q)
    );

    assign coils         = result_q.coils;
    assign stepped       = result_q.stepped;
    assign mode          = result_q.mode;
    assign holding       = result_q.holding;
    assign pending_calls = result_q.pending_calls;
    assign direction     = result_q.direction;

endmodule

@@ hw/rtl/ecc_checker.sv @@
`include "assert_macros.svh"

module ecc_checker
    import ecc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] coils,
    input logic       stepped,
    input logic [1:0] mode,
    input logic [1:0] direction
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_coils_stable, out_valid && !out_ready, $stable(coils))
    // Every reachable flag combination maps to stop, up or down
    `ASSERT_IMPL(a_mode_known, out_valid, mode != MODE_NONE)
    // A driven half step always records a travel direction and a lit winding
    `ASSERT_IMPL(a_step_dir, out_valid && stepped,
                 (direction == DIR_UP || direction == DIR_DOWN) && coils != 4'd0)

endmodule

bind elevator_call_controller_core ecc_checker u_ecc_checker (.*);
